// ===== src/polyline_equal_spacing_resampler_assert.svh =====
// Assertion macros for the polyline resampler
`ifndef POLYLINE_EQUAL_SPACING_RESAMPLER_ASSERT_SVH
`define POLYLINE_EQUAL_SPACING_RESAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define PESR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("check failed");
`define PESR_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("check failed");
`else
`define PESR_ASSERT(label, clk, rst_n, prop)
`define PESR_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== src/pesr_pkg.sv =====
// Shared types and constants of the polyline resampler
`timescale 1ns / 1ps
package pesr_pkg;
	localparam int COORD_W      = 24;
	localparam int DIFF_W       = 25;
	localparam int SQ_W         = 50;
	localparam int LEN_W        = 25;
	localparam int CARRY_W      = 25;
	localparam int MIN_SPACING  = 256;
	localparam int HALF_UNIT_SQ = 16384;

	typedef enum logic [4:0] {
		ST_IDLE, ST_FIRST, ST_DX, ST_DY, ST_SQRT, ST_CHECK, ST_MULX, ST_DIVX,
		ST_MULY, ST_DIVY, ST_PUT, ST_SEGEND, ST_END_DX, ST_END_DY, ST_END_CHK,
		ST_RD, ST_OUT
	} state_t;
endpackage

// ===== src/polyline_equal_spacing_resampler.sv =====
// Top level of the polyline equal-spacing resampler
//
//  channel  dir  handshake        payload
//  s_*      in   tvalid/tready    tdata {y,x}, tuser first_vertex, tlast final_vertex
//  m_*      out  tvalid/tready    tdata {y,x}, tuser {overflow,path_end}, tlast run_end
//  apb      in   psel/penable     register 0: spacing (24 bit Q16.8)
//
// One vertex request is worked at a time; s_tready stays low until its last sample leaves.
// First vertex: written to the buffer, then delivered. Segment: two serial squares, a serial
// root, a check and a close. Each sample adds two products, two quotients, a write and a
// remeasure of the segment. A final vertex adds the endpoint test.
// Each sample is read from the buffer, then offered; a stalled output holds its payload.
// Reset returns the sequencer to idle and the spacing to one unit.
`timescale 1ns / 1ps
`include "polyline_equal_spacing_resampler_assert.svh"
module polyline_equal_spacing_resampler #(
	parameter int MAX_SAMPLES_PER_SEGMENT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // [23:0] vertex_x, [47:24] vertex_y
	input  logic [0:0]  s_tuser,  // [0] first_vertex
	input  logic        s_tlast,  // final_vertex
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [23:0] sample_x, [47:24] sample_y
	output logic [1:0]  m_tuser,  // [0] path_end, [1] overflow
	output logic        m_tlast,  // run_end
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int MAX = MAX_SAMPLES_PER_SEGMENT;
	localparam int CW  = $clog2(MAX + 1);
	localparam int AW  = (MAX > 1) ? $clog2(MAX) : 1;
	localparam int CRW = pesr_pkg::COORD_W;
	localparam int DW  = pesr_pkg::DIFF_W;

	pesr_pkg::state_t state_q, state_d;
	logic enter_q;

	// configuration
	logic [23:0] spacing_q;
	logic [23:0] sp;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {8'd0, spacing_q};
	assign sp = (spacing_q < 24'(pesr_pkg::MIN_SPACING)) ? 24'(pesr_pkg::MIN_SPACING)
		: spacing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			spacing_q <= 24'(pesr_pkg::MIN_SPACING);
		else if (psel && penable && pwrite && !paddr[2])
			spacing_q <= pwdata[23:0];
	end

	// datapath state
	logic signed [CRW-1:0] cx_q, cy_q, px_q, py_q, lx_q, ly_q, nx_q, ny_q;
	logic fin_q, open_q, ovf_q;
	logic [pesr_pkg::CARRY_W-1:0] carried_q;
	logic [pesr_pkg::LEN_W-1:0]   seg_q, n_q;
	logic [pesr_pkg::SQ_W-1:0]    sq_q, sum_q, prod_q;
	logic [CW-1:0] cnt_q, rd_q, limit;
	logic accept;

	assign accept = s_tvalid && s_tready;
	assign limit  = fin_q ? CW'(MAX - 1) : CW'(MAX);

	// differences to the working point and to the last sample
	logic signed [DW-1:0] dx, dy, ex, ey;
	logic [DW-1:0] adx, ady, aex, aey;
	assign dx  = DW'(cx_q) - DW'(px_q);
	assign dy  = DW'(cy_q) - DW'(py_q);
	assign ex  = DW'(cx_q) - DW'(lx_q);
	assign ey  = DW'(cy_q) - DW'(ly_q);
	assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign aex = ex[DW-1] ? DW'(-ex) : DW'(ex);
	assign aey = ey[DW-1] ? DW'(-ey) : DW'(ey);

	logic [pesr_pkg::CARRY_W:0] reach;
	logic loop_go, end_put;
	assign reach   = {1'b0, carried_q} + {1'b0, seg_q};
	assign loop_go = (seg_q != '0) && (reach >= (pesr_pkg::CARRY_W + 1)'(sp));
	assign end_put = ovf_q || (sum_q > pesr_pkg::SQ_W'(pesr_pkg::HALF_UNIT_SQ));

	// shared serial units
	logic mul_start, sqrt_start, div_start, mul_done, sqrt_done, div_done;
	logic [DW-1:0] mul_a, mul_b;
	logic [pesr_pkg::SQ_W-1:0]  mul_p;
	logic [pesr_pkg::LEN_W-1:0] root, quo;

	pesr_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.p(mul_p), .done(mul_done)
	);
	pesr_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .radicand(sum_q),
		.root(root), .done(sqrt_done)
	);
	pesr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(prod_q), .den(seg_q),
		.quo(quo), .done(div_done)
	);

	// result buffer
	logic [2*CRW-1:0] mem [MAX];
	logic [2*CRW-1:0] rdata_q, wr_data;
	logic wr_en;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[cnt_q[AW-1:0]] <= wr_data;
		rdata_q <= mem[rd_q[AW-1:0]];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pesr_pkg::ST_IDLE:
				if (accept)
					state_d = (s_tuser[0] || !open_q) ? pesr_pkg::ST_FIRST : pesr_pkg::ST_DX;
			pesr_pkg::ST_FIRST:   state_d = pesr_pkg::ST_RD;
			pesr_pkg::ST_DX:      if (mul_done) state_d = pesr_pkg::ST_DY;
			pesr_pkg::ST_DY:      if (mul_done) state_d = pesr_pkg::ST_SQRT;
			pesr_pkg::ST_SQRT:    if (sqrt_done) state_d = pesr_pkg::ST_CHECK;
			pesr_pkg::ST_CHECK:
				state_d = (loop_go && cnt_q < limit) ? pesr_pkg::ST_MULX : pesr_pkg::ST_SEGEND;
			pesr_pkg::ST_MULX:    if (mul_done) state_d = pesr_pkg::ST_DIVX;
			pesr_pkg::ST_DIVX:    if (div_done) state_d = pesr_pkg::ST_MULY;
			pesr_pkg::ST_MULY:    if (mul_done) state_d = pesr_pkg::ST_DIVY;
			pesr_pkg::ST_DIVY:    if (div_done) state_d = pesr_pkg::ST_PUT;
			pesr_pkg::ST_PUT:     state_d = pesr_pkg::ST_DX;
			pesr_pkg::ST_SEGEND:
				if (fin_q)
					state_d = pesr_pkg::ST_END_DX;
				else
					state_d = (cnt_q == '0) ? pesr_pkg::ST_IDLE : pesr_pkg::ST_RD;
			pesr_pkg::ST_END_DX:  if (mul_done) state_d = pesr_pkg::ST_END_DY;
			pesr_pkg::ST_END_DY:  if (mul_done) state_d = pesr_pkg::ST_END_CHK;
			pesr_pkg::ST_END_CHK:
				state_d = (cnt_q == '0 && !end_put) ? pesr_pkg::ST_IDLE : pesr_pkg::ST_RD;
			pesr_pkg::ST_RD:      state_d = pesr_pkg::ST_OUT;
			pesr_pkg::ST_OUT:
				if (m_tready)
					state_d = (rd_q == cnt_q - CW'(1)) ? pesr_pkg::ST_IDLE : pesr_pkg::ST_RD;
			default:              state_d = pesr_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready   = 1'b0;
		m_tvalid   = 1'b0;
		mul_start  = 1'b0;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		mul_a      = adx;
		mul_b      = adx;
		wr_en      = 1'b0;
		wr_data    = {cy_q, cx_q};
		case (state_q)
			pesr_pkg::ST_IDLE:    s_tready = 1'b1;
			pesr_pkg::ST_FIRST:   wr_en = 1'b1;
			pesr_pkg::ST_DX:      mul_start = enter_q;
			pesr_pkg::ST_DY: begin
				mul_start = enter_q;
				mul_a     = ady;
				mul_b     = ady;
			end
			pesr_pkg::ST_SQRT:    sqrt_start = enter_q;
			pesr_pkg::ST_MULX: begin
				mul_start = enter_q;
				mul_b     = n_q;
			end
			pesr_pkg::ST_MULY: begin
				mul_start = enter_q;
				mul_a     = ady;
				mul_b     = n_q;
			end
			pesr_pkg::ST_DIVX,
			pesr_pkg::ST_DIVY:    div_start = enter_q;
			pesr_pkg::ST_PUT: begin
				wr_en   = 1'b1;
				wr_data = {ny_q, nx_q};
			end
			pesr_pkg::ST_END_DX: begin
				mul_start = enter_q;
				mul_a     = aex;
				mul_b     = aex;
			end
			pesr_pkg::ST_END_DY: begin
				mul_start = enter_q;
				mul_a     = aey;
				mul_b     = aey;
			end
			pesr_pkg::ST_END_CHK: wr_en = end_put;
			pesr_pkg::ST_OUT:     m_tvalid = 1'b1;
			default: ;
		endcase
	end

	assign m_tdata = rdata_q;
	assign m_tlast = (rd_q == cnt_q - CW'(1));
	assign m_tuser = {ovf_q, fin_q};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pesr_pkg::ST_IDLE;
			enter_q   <= 1'b0;
			open_q    <= 1'b0;
			carried_q <= '0;
			px_q      <= '0;
			py_q      <= '0;
			lx_q      <= '0;
			ly_q      <= '0;
			cnt_q     <= '0;
			rd_q      <= '0;
			ovf_q     <= 1'b0;
			fin_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			enter_q <= (state_d != state_q);
			case (state_q)
				pesr_pkg::ST_IDLE:
					if (accept) begin
						fin_q <= s_tlast;
						cnt_q <= '0;
						rd_q  <= '0;
						ovf_q <= 1'b0;
					end
				pesr_pkg::ST_FIRST: begin
					// a new path starts here: emit the vertex as is
					px_q      <= cx_q;
					py_q      <= cy_q;
					lx_q      <= cx_q;
					ly_q      <= cy_q;
					carried_q <= '0;
					open_q    <= !fin_q;
					cnt_q     <= CW'(1);
				end
				pesr_pkg::ST_CHECK:
					if (loop_go && cnt_q >= limit)
						ovf_q <= 1'b1;
				pesr_pkg::ST_PUT: begin
					// restart the walk from the new sample
					px_q      <= nx_q;
					py_q      <= ny_q;
					lx_q      <= nx_q;
					ly_q      <= ny_q;
					carried_q <= '0;
					cnt_q     <= cnt_q + CW'(1);
				end
				pesr_pkg::ST_SEGEND: begin
					carried_q <= ovf_q ? '0 : reach[pesr_pkg::CARRY_W-1:0];
					px_q      <= cx_q;
					py_q      <= cy_q;
					if (fin_q)
						open_q <= 1'b0;
				end
				pesr_pkg::ST_END_CHK:
					if (end_put) begin
						lx_q  <= cx_q;
						ly_q  <= cy_q;
						cnt_q <= cnt_q + CW'(1);
					end
				pesr_pkg::ST_OUT:
					if (m_tready)
						rd_q <= rd_q + CW'(1);
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q <= s_tdata[23:0];
			cy_q <= s_tdata[47:24];
		end
		if ((state_q == pesr_pkg::ST_DX || state_q == pesr_pkg::ST_END_DX) && mul_done)
			sq_q <= mul_p;
		if ((state_q == pesr_pkg::ST_DY || state_q == pesr_pkg::ST_END_DY) && mul_done)
			sum_q <= sq_q + mul_p;
		if (state_q == pesr_pkg::ST_SQRT && sqrt_done)
			seg_q <= root;
		if (state_q == pesr_pkg::ST_CHECK)
			// clamp the remaining distance at zero when spacing was lowered
			n_q <= ({1'b0, carried_q} >= (pesr_pkg::CARRY_W + 1)'(sp)) ? '0
				: pesr_pkg::LEN_W'({1'b0, sp} - {1'b0, carried_q[23:0]});
		if ((state_q == pesr_pkg::ST_MULX || state_q == pesr_pkg::ST_MULY) && mul_done)
			// add half the length to round to nearest
			prod_q <= mul_p + pesr_pkg::SQ_W'(seg_q >> 1);
		if (state_q == pesr_pkg::ST_DIVX && div_done)
			nx_q <= dx[DW-1] ? CRW'(px_q - CRW'(quo)) : CRW'(px_q + CRW'(quo));
		if (state_q == pesr_pkg::ST_DIVY && div_done)
			ny_q <= dy[DW-1] ? CRW'(py_q - CRW'(quo)) : CRW'(py_q + CRW'(quo));
	end

	`PESR_ASSERT(a_idle_no_out, clk, arst_n, s_tready |-> !m_tvalid)
	`PESR_ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > CW'(MAX))
	`PESR_ASSERT(a_last_to_idle, clk, arst_n, (m_tvalid && m_tready && m_tlast) |=> s_tready)
	`PESR_ASSERT(a_n_on_seg, clk, arst_n, (state_q == pesr_pkg::ST_MULX) |-> (n_q <= seg_q))
endmodule

// ===== src/pesr_mul.sv =====
// Bit-serial shift-add multiplier, 25 x 25 unsigned
`timescale 1ns / 1ps
module pesr_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pesr_pkg::DIFF_W-1:0]    a,
	input  logic [pesr_pkg::DIFF_W-1:0]    b,
	output logic [pesr_pkg::SQ_W-1:0]      p,
	output logic                           done
);
	logic [pesr_pkg::SQ_W-1:0]   acc_q, mc_q;
	logic [pesr_pkg::DIFF_W-1:0] mp_q;
	logic [4:0]                  cnt_q;
	logic                        busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(pesr_pkg::DIFF_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= {{(pesr_pkg::SQ_W - pesr_pkg::DIFF_W){1'b0}}, a};
			mp_q  <= b;
		end else if (busy_q) begin
			if (mp_q[0])
				acc_q <= acc_q + mc_q;
			mc_q <= {mc_q[pesr_pkg::SQ_W-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[pesr_pkg::DIFF_W-1:1]};
		end
	end

	assign p    = acc_q;
	assign done = done_q;
endmodule

// ===== src/pesr_sqrt.sv =====
// Digit-serial integer square root, two radicand bits per cycle
`timescale 1ns / 1ps
module pesr_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pesr_pkg::SQ_W-1:0]    radicand,
	output logic [pesr_pkg::LEN_W-1:0]   root,
	output logic                         done
);
	logic [pesr_pkg::SQ_W-1:0]  rad_q;
	logic [27:0]                rem_q, rem_n, trial;
	logic [pesr_pkg::LEN_W-1:0] root_q;
	logic [4:0]                 cnt_q;
	logic                       busy_q, done_q;

	assign rem_n = {rem_q[25:0], rad_q[pesr_pkg::SQ_W-1:pesr_pkg::SQ_W-2]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(pesr_pkg::LEN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[pesr_pkg::SQ_W-3:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[pesr_pkg::LEN_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[pesr_pkg::LEN_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign done = done_q;
endmodule

// ===== src/pesr_div.sv =====
// Bit-serial restoring divider, 50-bit dividend by 25-bit divisor
`timescale 1ns / 1ps
module pesr_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pesr_pkg::SQ_W-1:0]    num,
	input  logic [pesr_pkg::LEN_W-1:0]   den,
	output logic [pesr_pkg::LEN_W-1:0]   quo,
	output logic                         done
);
	logic [pesr_pkg::SQ_W-1:0]  num_q, q_q;
	logic [pesr_pkg::LEN_W-1:0] den_q;
	logic [pesr_pkg::LEN_W:0]   rem_q, r_n;
	logic [5:0]                 cnt_q;
	logic                       busy_q, done_q;

	assign r_n = {rem_q[pesr_pkg::LEN_W-1:0], num_q[pesr_pkg::SQ_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(pesr_pkg::SQ_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[pesr_pkg::SQ_W-2:0], 1'b0};
			if (r_n >= {1'b0, den_q}) begin
				rem_q <= r_n - {1'b0, den_q};
				q_q   <= {q_q[pesr_pkg::SQ_W-2:0], 1'b1};
			end else begin
				rem_q <= r_n;
				q_q   <= {q_q[pesr_pkg::SQ_W-2:0], 1'b0};
			end
		end
	end

	assign quo  = q_q[pesr_pkg::LEN_W-1:0];
	assign done = done_q;
endmodule
